// ===== hdl/cphc_pkg.sv =====
// Shared types and constants for the contactor pull-in/hold controller.
// Used by every module of the block; depends on nothing else.
package cphc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned IdW    = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_FRAME      = 2'd1,
    MODE_FORCE_OPEN = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAFE_WINDOW  = 3'd0,
    REG_PULL_IN_TIME = 3'd1,
    REG_PULL_IN_LVL  = 3'd2,
    REG_HOLD_LVL     = 3'd3,
    REG_ACTIVE_ID    = 3'd4,
    REG_NODE_ID      = 3'd5
  } reg_idx_t;

  localparam logic [LevelW-1:0] SafeWindowRst = 16'd300;
  localparam logic [LevelW-1:0] PullInTimeRst = 16'd2000;
  localparam logic [LevelW-1:0] PullInLvlRst  = 16'd999;
  localparam logic [LevelW-1:0] HoldLvlRst    = 16'd500;
  localparam logic [IdW-1:0]    ActiveIdRst   = 11'd1;
  localparam logic [IdW-1:0]    NodeIdRst     = 11'd3;

  typedef struct packed {
    logic [LevelW-1:0] safe_window_ms;
    logic [LevelW-1:0] pull_in_time_ms;
    logic [LevelW-1:0] pull_in_level;
    logic [LevelW-1:0] hold_level;
    logic [IdW-1:0]    active_frame_id;
    logic [IdW-1:0]    node_frame_id;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] drive_level;
    logic              is_closed;
  } result_t;

endpackage

// ===== hdl/cphc_cfg.sv =====
// Configuration register file for the contactor pull-in/hold controller.
// Depends on cphc_pkg for the register indexes, reset values and cfg_t.
module cphc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cphc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cphc_pkg::CfgDataW-1:0]  cfg_data,
  output cphc_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.safe_window_ms  <= cphc_pkg::SafeWindowRst;
      cfg.pull_in_time_ms <= cphc_pkg::PullInTimeRst;
      cfg.pull_in_level   <= cphc_pkg::PullInLvlRst;
      cfg.hold_level      <= cphc_pkg::HoldLvlRst;
      cfg.active_frame_id <= cphc_pkg::ActiveIdRst;
      cfg.node_frame_id   <= cphc_pkg::NodeIdRst;
    end else if (cfg_we) begin
      case (cphc_pkg::reg_idx_t'(cfg_index))
        cphc_pkg::REG_SAFE_WINDOW:  cfg.safe_window_ms  <= cfg_data;
        cphc_pkg::REG_PULL_IN_TIME: cfg.pull_in_time_ms <= cfg_data;
        cphc_pkg::REG_PULL_IN_LVL:  cfg.pull_in_level   <= cfg_data;
        cphc_pkg::REG_HOLD_LVL:     cfg.hold_level      <= cfg_data;
        cphc_pkg::REG_ACTIVE_ID:    cfg.active_frame_id <= cfg_data[cphc_pkg::IdW-1:0];
        cphc_pkg::REG_NODE_ID:      cfg.node_frame_id   <= cfg_data[cphc_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/cphc_core.sv =====
// Controller state and its combinational update for one beat.
// Depends on cphc_pkg; the result is the state as it stands after the beat.
module cphc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [1:0]                    mode,
  input  logic [cphc_pkg::TimeW-1:0]    now_ms,
  input  logic [cphc_pkg::IdW-1:0]      frame_id,
  input  cphc_pkg::cfg_t                cfg,
  output cphc_pkg::result_t             res_next
);

  logic                          request_pending, request_pending_next;
  logic [cphc_pkg::TimeW-1:0]    request_time, request_time_next;
  logic                          window_active, window_active_next;
  logic                          node_present, node_present_next;
  logic                          closed_flag, closed_flag_next;
  logic [cphc_pkg::TimeW-1:0]    close_time, close_time_next;
  logic                          pull_in_finished, pull_in_finished_next;
  logic [cphc_pkg::LevelW-1:0]   drive_register, drive_register_next;

  logic [cphc_pkg::TimeW-1:0]    window_age;
  logic [cphc_pkg::TimeW-1:0]    close_age;
  logic                          window_over;
  logic                          pull_in_over;
  logic                          win;
  logic                          pif;

  assign window_age   = now_ms - request_time;
  assign close_age    = now_ms - close_time;
  assign pull_in_over = close_age >= {16'd0, cfg.pull_in_time_ms};

  // A fresh request is stamped with now, so its age is zero.
  assign window_over = request_pending ? (cfg.safe_window_ms == '0)
                                       : (window_age >= {16'd0, cfg.safe_window_ms});

  always_comb begin
    request_pending_next  = request_pending;
    request_time_next     = request_time;
    window_active_next    = window_active;
    node_present_next     = node_present;
    closed_flag_next      = closed_flag;
    close_time_next       = close_time;
    pull_in_finished_next = pull_in_finished;
    drive_register_next   = drive_register;
    win = 1'b0;
    pif = 1'b0;

    case (cphc_pkg::mode_t'(mode))
      cphc_pkg::MODE_TICK: begin
        if (request_pending) begin
          request_pending_next = 1'b0;
          request_time_next    = now_ms;
        end
        win = (request_pending || window_active) && !window_over;
        window_active_next = win;
        if (win || !node_present) begin
          if (closed_flag) begin
            closed_flag_next    = 1'b0;
            drive_register_next = '0;
          end
        end else if (!closed_flag) begin
          closed_flag_next      = 1'b1;
          close_time_next       = now_ms;
          pull_in_finished_next = 1'b0;
          drive_register_next   = cfg.pull_in_level;
        end else begin
          pif = pull_in_finished || pull_in_over;
          pull_in_finished_next = pif;
          drive_register_next   = pif ? cfg.hold_level : cfg.pull_in_level;
        end
      end
      cphc_pkg::MODE_FRAME: begin
        if (frame_id == cfg.active_frame_id) begin
          request_pending_next = 1'b1;
        end else if (frame_id == cfg.node_frame_id) begin
          node_present_next = 1'b1;
        end
      end
      cphc_pkg::MODE_FORCE_OPEN: begin
        closed_flag_next    = 1'b0;
        drive_register_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_pending  <= 1'b0;
      request_time     <= '0;
      window_active    <= 1'b0;
      node_present     <= 1'b0;
      closed_flag      <= 1'b0;
      close_time       <= '0;
      pull_in_finished <= 1'b0;
      drive_register   <= '0;
    end else if (step) begin
      request_pending  <= request_pending_next;
      request_time     <= request_time_next;
      window_active    <= window_active_next;
      node_present     <= node_present_next;
      closed_flag      <= closed_flag_next;
      close_time       <= close_time_next;
      pull_in_finished <= pull_in_finished_next;
      drive_register   <= drive_register_next;
    end
  end

  assign res_next.drive_level = drive_register_next;
  assign res_next.is_closed   = closed_flag_next;

endmodule

// ===== hdl/contactor_pull_in_hold_controller.sv =====
// Top level of the contactor pull-in/hold controller: input beat register,
// result register and handshake. Depends on cphc_pkg, cphc_cfg and cphc_core.
//
// One result beat per input beat, one beat per clock cycle sustained while the
// output is not stalled. A beat waits in the input register while the state
// update and result are worked out, and these land in the result register, so
// a result reaches the output through the input register and then the result
// register. The result register holds while m_tvalid is high and m_tready is
// low, and the input register can then still take one more beat if empty.
// Tick beats close the contactor with pull-in drive once a node frame has been
// seen, and drop to hold drive after the pull-in time; safe-request frames
// make later ticks open it for the safe window; force-open beats open it at once.
module contactor_pull_in_hold_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,   // now_ms[31:0], frame_id[42:32], zero pad
  input  logic [1:0]                    s_tuser,   // mode[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // drive_level[15:0], is_closed[16], zero pad
  input  logic                          cfg_we,
  input  logic [cphc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cphc_pkg::CfgDataW-1:0] cfg_data
);

  logic                        in_valid;
  logic [1:0]                  in_mode;
  logic [cphc_pkg::TimeW-1:0]  in_now;
  logic [cphc_pkg::IdW-1:0]    in_fid;
  logic                        advance;
  cphc_pkg::cfg_t              cfg;
  cphc_pkg::result_t           res_next;
  cphc_pkg::result_t           res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser;
      in_now  <= s_tdata[31:0];
      in_fid  <= s_tdata[42:32];
    end
  end

  cphc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cphc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .mode     (in_mode),
    .now_ms   (in_now),
    .frame_id (in_fid),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {7'd0, res.is_closed, res.drive_level};

endmodule

// ===== verif/coil_drive_check_pkg.sv =====
// Predicts coil drive results for the contactor pull-in/hold controller and checks
// the result beats against them. Depends on cphc_pkg for the result and register types.
package coil_drive_check_pkg;
  import cphc_pkg::*;

  class coil_drive_scoreboard;
    bit [15:0] safe_window;
    bit [15:0] pull_in_time;
    bit [15:0] pull_in_lvl;
    bit [15:0] hold_lvl;
    bit [10:0] active_id;
    bit [10:0] node_id;
    bit        req_pending;
    bit [31:0] req_stamp;
    bit        window_on;
    bit        node_seen;
    bit        closed;
    bit [31:0] close_stamp;
    bit        pull_in_done;
    bit [15:0] drive;
    result_t   drive_due[$];
    int unsigned errors;

    function new();
      safe_window  = SafeWindowRst;
      pull_in_time = PullInTimeRst;
      pull_in_lvl  = PullInLvlRst;
      hold_lvl     = HoldLvlRst;
      active_id    = ActiveIdRst;
      node_id      = NodeIdRst;
      req_pending  = 1'b0;
      req_stamp    = '0;
      window_on    = 1'b0;
      node_seen    = 1'b0;
      closed       = 1'b0;
      close_stamp  = '0;
      pull_in_done = 1'b0;
      drive        = '0;
      errors       = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [15:0] value);
      case (idx)
        REG_SAFE_WINDOW:  safe_window  = value;
        REG_PULL_IN_TIME: pull_in_time = value;
        REG_PULL_IN_LVL:  pull_in_lvl  = value;
        REG_HOLD_LVL:     hold_lvl     = value;
        REG_ACTIVE_ID:    active_id    = value[10:0];
        REG_NODE_ID:      node_id      = value[10:0];
        default: ;
      endcase
    endfunction

    function void apply_tick(bit [31:0] now);
      bit [31:0] elapsed;
      if (req_pending) begin
        req_pending = 1'b0;
        req_stamp   = now;
        window_on   = 1'b1;
      end
      elapsed = now - req_stamp;
      if (window_on && elapsed >= {16'd0, safe_window}) begin
        window_on = 1'b0;
      end
      if (window_on || !node_seen) begin
        if (closed) begin
          closed = 1'b0;
          drive  = '0;
        end
      end else if (!closed) begin
        closed       = 1'b1;
        close_stamp  = now;
        pull_in_done = 1'b0;
        drive        = pull_in_lvl;
      end else begin
        elapsed = now - close_stamp;
        if (!pull_in_done && elapsed >= {16'd0, pull_in_time}) begin
          pull_in_done = 1'b1;
        end
        drive = pull_in_done ? hold_lvl : pull_in_lvl;
      end
    endfunction

    function void take_command(logic [1:0] mode, bit [31:0] now, bit [10:0] fid);
      result_t res;
      case (mode)
        MODE_TICK: apply_tick(now);
        MODE_FRAME: begin
          if (fid == active_id) begin
            req_pending = 1'b1;
          end else if (fid == node_id) begin
            node_seen = 1'b1;
          end
        end
        MODE_FORCE_OPEN: begin
          closed = 1'b0;
          drive  = '0;
        end
        default: ;
      endcase
      res.drive_level = drive;
      res.is_closed   = closed;
      drive_due.push_back(res);
    endfunction

    function void check_drive(logic [23:0] beat);
      result_t want;
      if (drive_due.size() == 0) begin
        errors++;
        $error("result beat with nothing expected: drive_level=%0d is_closed=%0b",
               beat[15:0], beat[16]);
        return;
      end
      want = drive_due.pop_front();
      if (beat[15:0] !== want.drive_level) begin
        errors++;
        $error("drive_level: expected %0d, actual %0d", want.drive_level, beat[15:0]);
      end
      if (beat[16] !== want.is_closed) begin
        errors++;
        $error("is_closed: expected %0b, actual %0b", want.is_closed, beat[16]);
      end
    endfunction
  endclass

endpackage

// ===== verif/contactor_pull_in_hold_controller_test.sv =====
// Self-checking testbench for contactor_pull_in_hold_controller: directed and random tick, frame,
// force-open and unused-mode beats with random idling. Depends on cphc_pkg and coil_drive_check_pkg.
module contactor_pull_in_hold_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cphc_pkg::*;
  import coil_drive_check_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned CycleLimit = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  coil_drive_scoreboard sb;
  bit [31:0]   clock_ms = '0;
  bit          steady_src = 1'b0;
  bit          steady_sink = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned cycles = 0;

  contactor_pull_in_hold_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.take_command(s_tuser, s_tdata[31:0], s_tdata[42:32]);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_drive(m_tdata);
    end
  end

  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      if (sink_hold != 0) begin
        m_tready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      if ($urandom_range(0, 39) == 0) steady_sink = !steady_sink;
      stall = steady_sink ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic [1:0] mode, input bit [31:0] now, input bit [10:0] fid);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) steady_src = !steady_src;
    gap = steady_src ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {5'd0, fid, now};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.drive_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input bit [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic program_regs(input bit [15:0] window, input bit [15:0] pull_in,
                              input bit [15:0] pull_lvl, input bit [15:0] hold,
                              input bit [10:0] active, input bit [10:0] node);
    wait_for_results();
    set_reg(REG_SAFE_WINDOW, window);
    set_reg(REG_PULL_IN_TIME, pull_in);
    set_reg(REG_PULL_IN_LVL, pull_lvl);
    set_reg(REG_HOLD_LVL, hold);
    set_reg(REG_ACTIVE_ID, {5'd0, active});
    set_reg(REG_NODE_ID, {5'd0, node});
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned pick;
    int unsigned span;
    bit [10:0]   fid;
    span = ((sb.safe_window > sb.pull_in_time) ? sb.safe_window : sb.pull_in_time) / 4 + 2;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, span);
        send_beat(MODE_TICK, clock_ms, 11'($urandom));
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0: fid = sb.active_id;
          1: fid = sb.node_id;
          default: fid = 11'($urandom);
        endcase
        send_beat(MODE_FRAME, $urandom, fid);
      end else if (pick < 94) begin
        send_beat(MODE_FORCE_OPEN, $urandom, 11'($urandom));
      end else begin
        send_beat(ModeUnused, $urandom, 11'($urandom));
      end
    end
  endtask

  initial begin
    bit [10:0] same_id;
    sb = new();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_beat(MODE_TICK, 32'd0, 11'd0);
    send_beat(ModeUnused, 32'hFFFF_FFFF, 11'h7FF);
    send_beat(MODE_FRAME, 32'd0, 11'h7FF);
    send_beat(MODE_FRAME, 32'hFFFF_FFFF, NodeIdRst);
    send_beat(MODE_TICK, 32'd10, 11'd0);
    send_beat(MODE_TICK, 32'd2009, 11'h7FF);
    send_beat(MODE_TICK, 32'd2010, 11'd0);
    send_beat(MODE_FRAME, 32'd0, ActiveIdRst);
    send_beat(MODE_TICK, 32'd2100, 11'd0);
    send_beat(MODE_TICK, 32'd2399, 11'd0);
    send_beat(MODE_TICK, 32'd2400, 11'd0);
    send_beat(MODE_FORCE_OPEN, 32'd0, 11'd0);
    send_beat(MODE_TICK, 32'd2401, 11'd0);
    send_beat(MODE_TICK, 32'hFFFF_FFF0, 11'd0);
    send_beat(ModeUnused, 32'd0, 11'd0);

    program_regs(16'd0, 16'd0, 16'hFFFF, 16'h0000, 11'd5, 11'd5);
    send_beat(MODE_FRAME, 32'd0, 11'd5);
    send_beat(MODE_TICK, 32'hFFFF_FFFF, 11'd0);
    send_beat(MODE_TICK, 32'd5, 11'd0);
    send_beat(MODE_FORCE_OPEN, 32'hFFFF_FFFF, 11'h7FF);
    send_beat(MODE_TICK, 32'd6, 11'd0);
    send_beat(MODE_TICK, 32'd6, 11'd0);
    send_beat(MODE_FRAME, 32'd0, 11'd5);
    send_beat(MODE_TICK, 32'd7, 11'd0);
    clock_ms = 32'd7;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(16'($urandom_range(1, 400)), 16'($urandom_range(1, 3000)),
                        16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom));
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF, 11'd0);
        2: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 11'd0, 11'h7FF);
        3: begin
          same_id = 11'($urandom);
          program_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                       16'($urandom), 16'($urandom), same_id, same_id);
          sink_hold = 120;
        end
        4: program_regs(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                        16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom));
        5: begin
          program_regs(16'($urandom_range(0, 5000)), 16'($urandom_range(0, 5000)),
                       16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom));
          clock_ms = 32'hFFFF_E000;
        end
        default: program_regs(16'($urandom), 16'($urandom_range(0, 3000)), 16'($urandom),
                              16'($urandom), 11'($urandom), 11'($urandom));
      endcase
      if (p == 4) begin
        run_phase(80);
        wait_for_results();
        run_phase(80);
      end else begin
        run_phase(160);
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== contactor_pull_in_hold_controller.f =====
hdl/cphc_pkg.sv
hdl/cphc_cfg.sv
hdl/cphc_core.sv
hdl/contactor_pull_in_hold_controller.sv
verif/coil_drive_check_pkg.sv
verif/contactor_pull_in_hold_controller_test.sv
